// ===== rtl/npfe_pkg.sv =====
// Shared types and constants for the NMEA position field extractor.
`default_nettype none

package npfe_pkg;

    localparam int BCD_W   = 40;
    localparam int CNT_W   = 4;
    localparam int NIBBLES = BCD_W / 4;
    localparam int HDR_W   = 48;
    localparam int WIN_W   = 40;

    // Header values as they sit in the six-byte window
    localparam logic [HDR_W-1:0] HDR_RMC = 48'h2447_5052_4D43; // "$GPRMC"
    localparam logic [HDR_W-1:0] HDR_GGA = 48'h2447_5047_4741; // "$GPGGA"

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_RMC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_GGA = 1'b1;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [CNT_W-1:0] count;
        logic             lon;
        logic             hemi;
        logic             ovf;
    } t_coord;

endpackage

`default_nettype wire

// ===== rtl/npfe_parse.sv =====
// Sentence tracker: header window, field capture and coordinate result.
`default_nettype none

module npfe_parse
    import npfe_pkg::*;
#(
    parameter int KEPT = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_acc,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_accept_rmc,
    input  wire logic       i_accept_gga,
    output logic            o_res_vld,
    output t_coord          o_res
);

    logic [WIN_W-1:0] r_win,     n_win;
    logic             r_in_sent, n_in_sent;
    logic [BCD_W-1:0] r_cur_bcd, n_cur_bcd;
    logic [CNT_W-1:0] r_cur_cnt, n_cur_cnt;
    logic             r_cur_ovf, n_cur_ovf;
    logic [BCD_W-1:0] r_cls_bcd, n_cls_bcd;
    logic [CNT_W-1:0] r_cls_cnt, n_cls_cnt;
    logic             r_cls_ovf, n_cls_ovf;

    logic [HDR_W-1:0] six;
    logic             hdr_hit;
    logic             is_digit;
    logic             is_trig;
    logic             is_lon;

    assign six      = {r_win, i_byte};
    assign hdr_hit  = (i_accept_rmc && six == HDR_RMC) || (i_accept_gga && six == HDR_GGA);
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_lon   = (i_byte == CH_E) || (i_byte == CH_W);
    assign is_trig  = (i_byte == CH_N) || (i_byte == CH_S) || is_lon;

    always_comb begin
        n_win     = r_win;
        n_in_sent = r_in_sent;
        n_cur_bcd = r_cur_bcd;
        n_cur_cnt = r_cur_cnt;
        n_cur_ovf = r_cur_ovf;
        n_cls_bcd = r_cls_bcd;
        n_cls_cnt = r_cls_cnt;
        n_cls_ovf = r_cls_ovf;
        o_res_vld = 1'b0;
        o_res.bcd   = r_cls_bcd;
        o_res.count = r_cls_cnt;
        o_res.lon   = is_lon;
        o_res.hemi  = (i_byte == CH_S) || (i_byte == CH_W);
        o_res.ovf   = r_cls_ovf;
        if (i_acc) begin
            n_win = six[WIN_W-1:0];
            if (!r_in_sent) begin
                // hunting: only a matched header matters
                if (hdr_hit) begin
                    n_in_sent = 1'b1;
                    n_cur_bcd = '0;
                    n_cur_cnt = '0;
                    n_cur_ovf = 1'b0;
                    n_cls_bcd = '0;
                    n_cls_cnt = '0;
                    n_cls_ovf = 1'b0;
                end
            end else if (i_byte == CH_COMMA) begin
                n_cls_bcd = r_cur_bcd;
                n_cls_cnt = r_cur_cnt;
                n_cls_ovf = r_cur_ovf;
                n_cur_bcd = '0;
                n_cur_cnt = '0;
                n_cur_ovf = 1'b0;
            end else if (is_digit) begin
                if (r_cur_cnt < CNT_W'(KEPT)) begin
                    for (int i = 0; i < NIBBLES; i++) begin
                        if (r_cur_cnt == CNT_W'(i)) begin
                            n_cur_bcd[BCD_W-1-4*i -: 4] = i_byte[3:0];
                        end
                    end
                    n_cur_cnt = r_cur_cnt + CNT_W'(1);
                end else begin
                    n_cur_ovf = 1'b1;
                end
            end else if (is_trig) begin
                o_res_vld = 1'b1;
                // E/W ends the sentence
                if (is_lon) begin
                    n_in_sent = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_in_sent <= 1'b0;
            r_cur_bcd <= '0;
            r_cur_cnt <= '0;
            r_cur_ovf <= 1'b0;
            r_cls_bcd <= '0;
            r_cls_cnt <= '0;
            r_cls_ovf <= 1'b0;
        end else begin
            r_win     <= n_win;
            r_in_sent <= n_in_sent;
            r_cur_bcd <= n_cur_bcd;
            r_cur_cnt <= n_cur_cnt;
            r_cur_ovf <= n_cur_ovf;
            r_cls_bcd <= n_cls_bcd;
            r_cls_cnt <= n_cls_cnt;
            r_cls_ovf <= n_cls_ovf;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nmea_position_field_extractor.sv =====
// Top level of the NMEA position field extractor: config, parser and output queue.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------------------
//  in      | into      | i_in_valid / o_in_stall | i_rx_byte
//  out     | out of    | o_out_valid/i_out_stall | o_coord_bcd, o_digit_count,
//          |           |                         | o_is_longitude, o_hemisphere,
//          |           |                         | o_overflow
//  cfg     | into      | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One byte is taken per cycle while o_in_stall is low; the parser updates its
// state at the accepting edge, and a coordinate word, if the byte is N/S/E/W
// inside a sentence, lands in the output register or the skid register at that same edge.
// A second (skid) register catches a word while the output is stalled;
// o_in_stall is raised only while that skid register is full.
// Reset is synchronous and active low; it clears all control state and sets
// both header enables.
`default_nettype none

module nmea_position_field_extractor
    import npfe_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [BCD_W-1:0]          o_coord_bcd,
    output logic [CNT_W-1:0]          o_digit_count,
    output logic                      o_is_longitude,
    output logic                      o_hemisphere,
    output logic                      o_overflow,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                 i_cfg_data
);

    // digits kept per field: never more than the BCD word holds
    localparam int KEPT = (MAX_DIGITS < NIBBLES) ? MAX_DIGITS : NIBBLES;

    logic   r_acc_rmc;
    logic   r_acc_gga;
    logic   r_out_vld;
    logic   r_skd_vld;
    t_coord r_out;
    t_coord r_skd;

    logic   in_acc;
    logic   out_fire;
    logic   res_vld;
    t_coord res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_fire = r_out_vld && !i_out_stall;

    // Configuration registers, write-only: user writes only while idle; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_rmc <= 1'b1;
            r_acc_gga <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEPT_RMC: r_acc_rmc <= i_cfg_data;
                CFG_ACCEPT_GGA: r_acc_gga <= i_cfg_data;
                default: ;
            endcase
        end
    end

    npfe_parse #(
        .KEPT (KEPT)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (in_acc),
        .i_byte       (i_rx_byte),
        .i_accept_rmc (r_acc_rmc),
        .i_accept_gga (r_acc_gga),
        .o_res_vld    (res_vld),
        .o_res        (res)
    );

    // Output register with skid: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            // input is held off; drain skid into output
            if (out_fire) begin
                r_skd_vld <= 1'b0;
            end
        end else if (res_vld) begin
            if (r_out_vld && !out_fire) begin
                r_skd_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_vld <= 1'b0;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (out_fire) begin
                r_out <= r_skd;
            end
        end else if (res_vld) begin
            if (r_out_vld && !out_fire) begin
                r_skd <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_in_stall     = r_skd_vld;
    assign o_out_valid    = r_out_vld;
    assign o_coord_bcd    = r_out.bcd;
    assign o_digit_count  = r_out.count;
    assign o_is_longitude = r_out.lon;
    assign o_hemisphere   = r_out.hemi;
    assign o_overflow     = r_out.ovf;

    // skid never holds a word ahead of an empty output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    // a stalled full output with a new result must fill the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall && res_vld) |=> r_skd_vld)
        else $error("result dropped while output stalled");

    // digit count stays within the kept limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_count <= CNT_W'(KEPT)))
        else $error("digit count beyond kept limit");

    // overflow only ever follows a full field
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_digit_count == CNT_W'(KEPT)))
        else $error("overflow flagged on a field that was not full");

endmodule

`default_nettype wire

// ===== dv/nmea_position_field_extractor_test.sv =====
// Self-checking testbench for the NMEA position field extractor.
`default_nettype none

import npfe_pkg::*;

// Tracks the parser state byte by byte and holds the coordinate words still to come.
class coord_tracker;
    t_coord           pending_coords[$];
    int               mismatches;
    int               parsed_bytes;
    int               keep;
    logic             rmc_on;
    logic             gga_on;
    logic [WIN_W-1:0] window;
    logic             in_sentence;
    logic [BCD_W-1:0] cur_bcd;
    int               cur_cnt;
    logic             cur_ovf;
    logic [BCD_W-1:0] done_bcd;
    int               done_cnt;
    logic             done_ovf;

    function new(int max_digits);
        keep        = (max_digits < NIBBLES) ? max_digits : NIBBLES;
        mismatches  = 0;
        parsed_bytes = 0;
        rmc_on      = 1'b1;
        gga_on      = 1'b1;
        window      = '0;
        in_sentence = 1'b0;
        clear_fields();
    endfunction

    function void clear_fields();
        cur_bcd  = '0;
        cur_cnt  = 0;
        cur_ovf  = 1'b0;
        done_bcd = '0;
        done_cnt = 0;
        done_ovf = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic data);
        if (idx == CFG_ACCEPT_RMC)
            rmc_on = data;
        else if (idx == CFG_ACCEPT_GGA)
            gga_on = data;
    endfunction

    // Advance the parser by one accepted byte; queue a word on N/S/E/W inside a sentence.
    function void take_byte(logic [7:0] b);
        logic [HDR_W-1:0] six;
        t_coord           word;
        six    = {window, b};
        window = six[WIN_W-1:0];
        if (!in_sentence) begin
            if ((rmc_on && six == HDR_RMC) || (gga_on && six == HDR_GGA)) begin
                in_sentence = 1'b1;
                parsed_bytes++;
                clear_fields();
            end
            return;
        end
        parsed_bytes++;
        if (b == CH_COMMA) begin
            done_bcd = cur_bcd;
            done_cnt = cur_cnt;
            done_ovf = cur_ovf;
            cur_bcd  = '0;
            cur_cnt  = 0;
            cur_ovf  = 1'b0;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (cur_cnt < keep) begin
                cur_bcd[BCD_W - 4 - 4 * cur_cnt +: 4] = 4'(b - CH_ZERO);
                cur_cnt++;
            end else begin
                cur_ovf = 1'b1;
            end
        end else if (b == CH_N || b == CH_S || b == CH_E || b == CH_W) begin
            word.bcd   = done_bcd;
            word.count = CNT_W'(done_cnt);
            word.lon   = (b == CH_E || b == CH_W);
            word.hemi  = (b == CH_S || b == CH_W);
            word.ovf   = done_ovf;
            pending_coords.push_back(word);
            // longitude closes the sentence: back to hunting
            if (word.lon)
                in_sentence = 1'b0;
        end
    endfunction

    function void compare_field(string name, logic [BCD_W-1:0] want, logic [BCD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void match_coord(t_coord got);
        t_coord want;
        if (pending_coords.size() == 0) begin
            $display("%0t: unexpected word, bcd %h count %0d lon %b hemi %b ovf %b",
                     $time, got.bcd, got.count, got.lon, got.hemi, got.ovf);
            mismatches++;
            return;
        end
        want = pending_coords.pop_front();
        compare_field("coord_bcd", want.bcd, got.bcd);
        compare_field("digit_count", BCD_W'(want.count), BCD_W'(got.count));
        compare_field("is_longitude", BCD_W'(want.lon), BCD_W'(got.lon));
        compare_field("hemisphere", BCD_W'(want.hemi), BCD_W'(got.hemi));
        compare_field("overflow", BCD_W'(want.ovf), BCD_W'(got.ovf));
    endfunction
endclass

module nmea_position_field_extractor_test;

    localparam int MAX_DIGITS   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ACTIVE_BYTES = 52;
    localparam int QUIET_BYTES  = 25;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BCD_W-1:0]     o_coord_bcd;
    logic [CNT_W-1:0]     o_digit_count;
    logic                 o_is_longitude;
    logic                 o_hemisphere;
    logic                 o_overflow;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic                 i_cfg_data = 1'b0;

    coord_tracker tracker;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           bytes_sent = 0;
    int           cycle_count = 0;

    nmea_position_field_extractor #(
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coord_bcd    (o_coord_bcd),
        .o_digit_count  (o_digit_count),
        .o_is_longitude (o_is_longitude),
        .o_hemisphere   (o_hemisphere),
        .o_overflow     (o_overflow),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nmea_position_field_extractor_test NOT OK");
            $finish;
        end
    end

    // Stall the output at random, one decision per cycle.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            tracker.match_coord({o_coord_bcd, o_digit_count, o_is_longitude,
                                 o_hemisphere, o_overflow});
    end

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.take_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic send_digits(input int n);
        int dot_at;
        dot_at = $urandom_range(n + 3);
        for (int i = 0; i < n; i++) begin
            if (i == dot_at)
                push_byte(".");
            push_byte(8'(CH_ZERO + $urandom_range(9)));
        end
    endtask

    function automatic int field_len();
        return ($urandom_range(7) == 0) ? $urandom_range(14, 11) : $urandom_range(10);
    endfunction

    // One sentence with random content; now and then cut short or garbled.
    task automatic send_sentence();
        string hdr;
        hdr = $urandom_range(1) ? "$GPRMC" : "$GPGGA";
        repeat ($urandom_range(3))
            push_byte(8'($urandom_range(255)));
        if ($urandom_range(11) == 0) begin
            send_text(hdr.substr(0, $urandom_range(4)));
            push_byte(8'($urandom_range(255)));
            return;
        end
        send_text(hdr);
        push_byte(CH_COMMA);
        send_digits($urandom_range(6));
        push_byte(CH_COMMA);
        if (hdr == "$GPRMC")
            send_text("A,");
        send_digits(field_len());
        if ($urandom_range(7) == 0)
            push_byte(8'($urandom_range(255)));
        push_byte(CH_COMMA);
        push_byte($urandom_range(1) ? CH_S : CH_N);
        push_byte(CH_COMMA);
        send_digits(field_len());
        push_byte(CH_COMMA);
        // drop the E/W now and then: the sentence stays open
        if ($urandom_range(9) != 0)
            push_byte($urandom_range(1) ? CH_W : CH_E);
        send_text(",*");
        push_byte(8'($urandom_range(255)));
        push_byte(8'($urandom_range(255)));
        push_byte(8'h0D);
        push_byte(8'h0A);
    endtask

    // Hold the input, wait out every pending word, then let the pipe settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.pending_coords.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_headers(input logic rmc, input logic gga);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ACCEPT_RMC;
        i_cfg_data <= rmc;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ACCEPT_GGA;
        i_cfg_data <= gga;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_reg(CFG_ACCEPT_RMC, rmc);
        tracker.set_reg(CFG_ACCEPT_GGA, gga);
    endtask

    initial begin
        int target;
        logic rmc;
        logic gga;
        tracker = new(MAX_DIGITS);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Hunting ignores extreme bytes and triggers; an overflowing latitude,
        // a header inside a sentence that must not restart it, an empty longitude.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_E);
        send_text("$GPGGA,012345678956,S$GPRMC,W");

        for (int k = 0; k < 16; k++) begin
            wait_drained();
            case (k / 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 78;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 78;
                end
                default: begin
                    send_idle_pct = 8;
                    stall_pct     = 8;
                end
            endcase
            rmc = (k % 2 == 0);
            gga = ((k / 2) % 2 == 0);
            set_headers(rmc, gga);
            if (rmc || gga) begin
                target = tracker.parsed_bytes + ACTIVE_BYTES;
                while (tracker.parsed_bytes < target)
                    send_sentence();
            end else begin
                target = bytes_sent + QUIET_BYTES;
                while (bytes_sent < target)
                    send_sentence();
            end
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_coords.size() == 0)
            $display("nmea_position_field_extractor_test OK");
        else
            $display("nmea_position_field_extractor_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/npfe_pkg.sv
rtl/npfe_parse.sv
rtl/nmea_position_field_extractor.sv
dv/nmea_position_field_extractor_test.sv
